/* rtl/aldp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldp_pkg
// Shared types and constants for the area light direction pdf block.
// ----------------------------------------------------------------------------
`default_nettype none

package aldp_pkg;

    // configuration register indexes
    localparam logic CFG_LIGHT_WIDTH  = 1'b0;
    localparam logic CFG_LIGHT_HEIGHT = 1'b1;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // square root and divider geometry
    localparam int SQ_STEPS = 24;   // result bits of sqrt(q * 2^16)
    localparam int REM_W    = 27;   // sqrt partial remainder
    localparam int NUM_W    = 126;  // numerator, below 2^126
    localparam int DEN_W    = 112;  // denominator, below 2^109
    localparam int WIDE_W   = 144;  // den shifted by up to 32
    localparam int QUO_W    = 32;

    // one classified item handed from front to back
    typedef struct packed {
        logic               hit;
        logic [31:0]        py;
        logic signed [15:0] dx;
        logic signed [15:0] dz;
        logic [15:0]        m;
    } t_item;

endpackage

`default_nettype wire

/* rtl/aldp_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldp_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module aldp_fifo (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire aldp_pkg::t_item  i_item,
    input  wire                   i_pop,
    output aldp_pkg::t_item       o_head,
    output logic                  o_full,
    output logic                  o_empty
);

    aldp_pkg::t_item                 r_mem [0:aldp_pkg::FIFO_DEPTH-1];
    logic [aldp_pkg::FIFO_AW-1:0]    r_wptr;
    logic [aldp_pkg::FIFO_AW-1:0]    r_rptr;
    logic [aldp_pkg::FIFO_CW-1:0]    r_count;

    assign o_full  = (r_count == aldp_pkg::FIFO_CW'(aldp_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/aldp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldp_front
// Accepts transactions and classifies them: miss cases and rectangle test.
// ----------------------------------------------------------------------------
`default_nettype none

module aldp_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire  [31:0]          i_point_x,
    input  wire  [31:0]          i_point_y,
    input  wire  [31:0]          i_point_z,
    input  wire  [15:0]          i_dir_x,
    input  wire  [15:0]          i_dir_y,
    input  wire  [15:0]          i_dir_z,
    input  wire  [31:0]          i_light_width,
    input  wire  [31:0]          i_light_height,
    output logic                 o_push,
    output aldp_pkg::t_item      o_item,
    input  wire                  i_full
);

    // input register
    logic               r_s0_valid;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [15:0] r_dx, r_dy, r_dz;

    // product register
    logic               r_s1_valid;
    logic               r_miss;
    logic signed [48:0] r_pxm, r_dxpy, r_pzm, r_dzpy;
    logic [47:0]        r_wm, r_hm;
    logic [31:0]        r_py1;
    logic signed [15:0] r_dx1, r_dz1;
    logic [15:0]        r_m1;

    logic               w_accept, w_s0_mv;
    logic [15:0]        w_m;
    logic               w_miss;
    logic signed [48:0] w_xn, w_zn;
    logic [48:0]        w_xa, w_za;
    logic               w_in_x, w_in_z;

    assign o_push     = r_s1_valid && !i_full;
    assign w_s0_mv    = r_s0_valid && (!r_s1_valid || o_push);
    assign o_in_stall = r_s0_valid && !w_s0_mv;
    assign w_accept   = i_in_valid && !o_in_stall;

    // m = -dir_y; only meaningful for downward directions
    assign w_m    = 16'd0 - r_dy;
    assign w_miss = r_py[31] || (r_py == '0) || !r_dy[15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s0_valid <= 1'b1;
            end else if (w_s0_mv) begin
                r_s0_valid <= 1'b0;
            end
            if (w_s0_mv) begin
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_pz <= i_point_z;
            r_dx <= i_dir_x;
            r_dy <= i_dir_y;
            r_dz <= i_dir_z;
        end
        if (w_s0_mv) begin
            r_miss <= w_miss;
            r_pxm  <= r_px * $signed({1'b0, w_m});
            r_pzm  <= r_pz * $signed({1'b0, w_m});
            r_dxpy <= r_dx * r_py;
            r_dzpy <= r_dz * r_py;
            r_wm   <= 48'(i_light_width) * 48'(w_m);
            r_hm   <= 48'(i_light_height) * 48'(w_m);
            r_py1  <= r_py;
            r_dx1  <= r_dx;
            r_dz1  <= r_dz;
            r_m1   <= w_m;
        end
    end

    // open rectangle test: 2|X| < w*m and 2|Z| < h*m
    always_comb begin
        w_xn   = r_pxm + r_dxpy;
        w_zn   = r_pzm + r_dzpy;
        w_xa   = w_xn[48] ? 49'(-w_xn) : 49'(w_xn);
        w_za   = w_zn[48] ? 49'(-w_zn) : 49'(w_zn);
        w_in_x = {w_xa[47:0], 1'b0} < {1'b0, r_wm};
        w_in_z = {w_za[47:0], 1'b0} < {1'b0, r_hm};
        o_item.hit = !r_miss && w_in_x && w_in_z;
        o_item.py  = r_py1;
        o_item.dx  = r_dx1;
        o_item.dz  = r_dz1;
        o_item.m   = r_m1;
    end

endmodule

`default_nettype wire

/* rtl/aldp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldp_back
// Pdf datapath: products, pipelined square root, pipelined divider.
// ----------------------------------------------------------------------------
`default_nettype none

module aldp_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire aldp_pkg::t_item i_head,
    input  wire                  i_empty,
    output logic                 o_pop,
    input  wire  [31:0]          i_light_width,
    input  wire  [31:0]          i_light_height,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output logic                 o_hit,
    output logic [31:0]          o_pdf_value,
    output logic                 o_saturated
);

    localparam int SQN = aldp_pkg::SQ_STEPS;
    localparam int DVN = aldp_pkg::QUO_W;

    logic w_adv;

    // B1: squares, w*h
    logic        r_b1_v, r_b1_hit;
    logic [63:0] r_b1_py2, r_b1_wh;
    logic [31:0] r_b1_dx2, r_b1_dz2, r_b1_m2;
    logic [15:0] r_b1_m;
    // B2: q, m^3
    logic        r_b2_v, r_b2_hit;
    logic [31:0] r_b2_q;
    logic [47:0] r_b2_m3;
    logic [63:0] r_b2_py2, r_b2_wh;
    // B3: denominator partial products
    logic        r_b3_v, r_b3_hit;
    logic [31:0] r_b3_q;
    logic [63:0] r_b3_py2;
    logic [63:0] r_b3_pll, r_b3_plh;
    logic [47:0] r_b3_phl, r_b3_phh;

    // square root stages, entry 0 holds the summed denominator
    logic                           r_sq_v    [0:SQN];
    logic                           r_sq_hit  [0:SQN];
    logic [31:0]                    r_sq_q    [0:SQN];
    logic [63:0]                    r_sq_py2  [0:SQN];
    logic [aldp_pkg::DEN_W-1:0]     r_sq_den  [0:SQN];
    logic [47:0]                    r_sq_x    [0:SQN];
    logic [aldp_pkg::REM_W-1:0]     r_sq_rem  [0:SQN];
    logic [SQN-1:0]                 r_sq_root [0:SQN];
    logic [aldp_pkg::REM_W-1:0]     n_sq_rem  [1:SQN];
    logic [SQN-1:0]                 n_sq_root [1:SQN];
    logic [aldp_pkg::REM_W-1:0]     w_sq_sh   [1:SQN];
    logic [aldp_pkg::REM_W-1:0]     w_sq_tr   [1:SQN];

    // numerator stages
    logic                       r_p1_v, r_p1_hit;
    logic [55:0]                r_p1_b;
    logic [63:0]                r_p1_py2;
    logic [aldp_pkg::DEN_W-1:0] r_p1_den;
    logic                       r_p2_v, r_p2_hit;
    logic [63:0]                r_p2_pa, r_p2_pc;
    logic [55:0]                r_p2_pb, r_p2_pd;
    logic [aldp_pkg::DEN_W-1:0] r_p2_den;

    // divider stages, entry 0 holds the saturation check
    logic                        r_dv_v   [0:DVN];
    logic                        r_dv_hit [0:DVN];
    logic                        r_dv_sat [0:DVN];
    logic [aldp_pkg::NUM_W-1:0]  r_dv_rem [0:DVN];
    logic [aldp_pkg::DEN_W-1:0]  r_dv_den [0:DVN];
    logic [DVN-1:0]              r_dv_quo [0:DVN];
    logic [aldp_pkg::NUM_W-1:0]  n_dv_rem [1:DVN];
    logic [DVN-1:0]              n_dv_quo [1:DVN];
    logic [aldp_pkg::WIDE_W-1:0] w_dv_cmp [1:DVN];

    logic [aldp_pkg::NUM_W-1:0]  w_num;
    logic                        w_sat;

    logic        r_out_valid;
    logic        r_hit, r_saturated;
    logic [31:0] r_pdf;

    assign w_adv       = !(r_out_valid && i_out_stall);
    assign o_pop       = w_adv && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_pdf_value = r_pdf;
    assign o_saturated = r_saturated;

    // restoring square root, one result bit per stage
    always_comb begin
        for (int i = 1; i <= SQN; i++) begin
            w_sq_sh[i] = {r_sq_rem[i-1][aldp_pkg::REM_W-3:0], r_sq_x[i-1][49-2*i -: 2]};
            w_sq_tr[i] = {1'b0, r_sq_root[i-1], 2'b01};
            if (w_sq_sh[i] >= w_sq_tr[i]) begin
                n_sq_rem[i]  = w_sq_sh[i] - w_sq_tr[i];
                n_sq_root[i] = {r_sq_root[i-1][SQN-2:0], 1'b1};
            end else begin
                n_sq_rem[i]  = w_sq_sh[i];
                n_sq_root[i] = {r_sq_root[i-1][SQN-2:0], 1'b0};
            end
        end
    end

    // numerator sum and saturation compare
    always_comb begin
        w_num = (aldp_pkg::NUM_W'(r_p2_pa)
               + (aldp_pkg::NUM_W'(r_p2_pb) << 32)
               + (aldp_pkg::NUM_W'(r_p2_pc) << 32)
               + (aldp_pkg::NUM_W'(r_p2_pd) << 64)) << 8;
        w_sat = aldp_pkg::WIDE_W'(w_num) >= (aldp_pkg::WIDE_W'(r_p2_den) << 32);
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int j = 1; j <= DVN; j++) begin
            w_dv_cmp[j] = aldp_pkg::WIDE_W'(r_dv_den[j-1]) << (DVN - j);
            if (aldp_pkg::WIDE_W'(r_dv_rem[j-1]) >= w_dv_cmp[j]) begin
                n_dv_rem[j] = r_dv_rem[j-1] - w_dv_cmp[j][aldp_pkg::NUM_W-1:0];
                n_dv_quo[j] = r_dv_quo[j-1] | (DVN'(1) << (DVN - j));
            end else begin
                n_dv_rem[j] = r_dv_rem[j-1];
                n_dv_quo[j] = r_dv_quo[j-1];
            end
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v      <= 1'b0;
            r_b2_v      <= 1'b0;
            r_b3_v      <= 1'b0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i <= SQN; i++) begin
                r_sq_v[i] <= 1'b0;
            end
            for (int j = 0; j <= DVN; j++) begin
                r_dv_v[j] <= 1'b0;
            end
        end else if (w_adv) begin
            r_b1_v    <= o_pop;
            r_b2_v    <= r_b1_v;
            r_b3_v    <= r_b2_v;
            r_sq_v[0] <= r_b3_v;
            for (int i = 1; i <= SQN; i++) begin
                r_sq_v[i] <= r_sq_v[i-1];
            end
            r_p1_v    <= r_sq_v[SQN];
            r_p2_v    <= r_p1_v;
            r_dv_v[0] <= r_p2_v;
            for (int j = 1; j <= DVN; j++) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
            r_out_valid <= r_dv_v[DVN];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b1_hit <= i_head.hit;
            r_b1_py2 <= 64'(i_head.py) * 64'(i_head.py);
            r_b1_dx2 <= 32'(i_head.dx * i_head.dx);
            r_b1_dz2 <= 32'(i_head.dz * i_head.dz);
            r_b1_m2  <= 32'(i_head.m) * 32'(i_head.m);
            r_b1_m   <= i_head.m;
            r_b1_wh  <= 64'(i_light_width) * 64'(i_light_height);

            r_b2_hit <= r_b1_hit;
            r_b2_q   <= r_b1_dx2 + r_b1_m2 + r_b1_dz2;
            r_b2_m3  <= 48'(r_b1_m2) * 48'(r_b1_m);
            r_b2_py2 <= r_b1_py2;
            r_b2_wh  <= r_b1_wh;

            r_b3_hit <= r_b2_hit;
            r_b3_q   <= r_b2_q;
            r_b3_py2 <= r_b2_py2;
            r_b3_pll <= 64'(r_b2_m3[31:0]) * 64'(r_b2_wh[31:0]);
            r_b3_plh <= 64'(r_b2_m3[31:0]) * 64'(r_b2_wh[63:32]);
            r_b3_phl <= 48'(r_b2_m3[47:32]) * 48'(r_b2_wh[31:0]);
            r_b3_phh <= 48'(r_b2_m3[47:32]) * 48'(r_b2_wh[63:32]);

            r_sq_hit[0]  <= r_b3_hit;
            r_sq_q[0]    <= r_b3_q;
            r_sq_py2[0]  <= r_b3_py2;
            r_sq_den[0]  <= aldp_pkg::DEN_W'(r_b3_pll)
                          + (aldp_pkg::DEN_W'(r_b3_plh) << 32)
                          + (aldp_pkg::DEN_W'(r_b3_phl) << 32)
                          + (aldp_pkg::DEN_W'(r_b3_phh) << 64);
            r_sq_x[0]    <= {r_b3_q, 16'd0};
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            for (int i = 1; i <= SQN; i++) begin
                r_sq_hit[i]  <= r_sq_hit[i-1];
                r_sq_q[i]    <= r_sq_q[i-1];
                r_sq_py2[i]  <= r_sq_py2[i-1];
                r_sq_den[i]  <= r_sq_den[i-1];
                r_sq_x[i]    <= r_sq_x[i-1];
                r_sq_rem[i]  <= n_sq_rem[i];
                r_sq_root[i] <= n_sq_root[i];
            end

            // B = q * sqrt(q) with 8 fraction bits
            r_p1_hit <= r_sq_hit[SQN];
            r_p1_b   <= 56'(r_sq_q[SQN]) * 56'(r_sq_root[SQN]);
            r_p1_py2 <= r_sq_py2[SQN];
            r_p1_den <= r_sq_den[SQN];

            r_p2_hit <= r_p1_hit;
            r_p2_pa  <= 64'(r_p1_py2[31:0]) * 64'(r_p1_b[31:0]);
            r_p2_pb  <= 56'(r_p1_py2[31:0]) * 56'(r_p1_b[55:32]);
            r_p2_pc  <= 64'(r_p1_py2[63:32]) * 64'(r_p1_b[31:0]);
            r_p2_pd  <= 56'(r_p1_py2[63:32]) * 56'(r_p1_b[55:32]);
            r_p2_den <= r_p1_den;

            r_dv_hit[0] <= r_p2_hit;
            r_dv_sat[0] <= w_sat;
            r_dv_rem[0] <= w_num;
            r_dv_den[0] <= r_p2_den;
            r_dv_quo[0] <= '0;
            for (int j = 1; j <= DVN; j++) begin
                r_dv_hit[j] <= r_dv_hit[j-1];
                r_dv_sat[j] <= r_dv_sat[j-1];
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_den[j] <= r_dv_den[j-1];
                r_dv_quo[j] <= n_dv_quo[j];
            end

            r_hit       <= r_dv_hit[DVN];
            r_saturated <= r_dv_hit[DVN] && r_dv_sat[DVN];
            if (!r_dv_hit[DVN]) begin
                r_pdf <= '0;
            end else if (r_dv_sat[DVN]) begin
                r_pdf <= '1;
            end else begin
                r_pdf <= r_dv_quo[DVN];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/area_light_direction_pdf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// area_light_direction_pdf
// Solid-angle pdf of a direction toward a rectangular area light in y=0.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the output is not stalled; set by
//   the single-pass pipelines of the 24-stage square root and the 32-stage divider.
// Reset (i_rst_n low, synchronous): all pipelines and the queue empty,
//   light_width and light_height back to 1.0 (Q16.16).
// ----------------------------------------------------------------------------
`default_nettype none

module area_light_direction_pdf (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_wr_en,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [31:0] i_point_x,
    input  wire  [31:0] i_point_y,
    input  wire  [31:0] i_point_z,
    input  wire  [15:0] i_dir_x,
    input  wire  [15:0] i_dir_y,
    input  wire  [15:0] i_dir_z,
    // output channel
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_hit,
    output logic [31:0] o_pdf_value,
    output logic        o_saturated
);

    // Light size registers. The user must write them only while the block is
    // idle; the block does not enforce it. Both datapath halves read them directly.
    logic [31:0] r_light_width;
    logic [31:0] r_light_height;

    // front -> queue -> back
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    aldp_pkg::t_item w_item;
    aldp_pkg::t_item w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_width  <= 32'h0001_0000;
            r_light_height <= 32'h0001_0000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                aldp_pkg::CFG_LIGHT_WIDTH:  r_light_width  <= i_cfg_data;
                aldp_pkg::CFG_LIGHT_HEIGHT: r_light_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front: takes each transaction, flags the miss cases (point on or below
    // the plane, direction not downward) and runs the open-rectangle test.
    aldp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_dir_x        (i_dir_x),
        .i_dir_y        (i_dir_y),
        .i_dir_z        (i_dir_z),
        .i_light_width  (r_light_width),
        .i_light_height (r_light_height),
        .o_push         (w_push),
        .o_item         (w_item),
        .i_full         (w_full)
    );

    // Queue so the front keeps accepting, until it fills, while the back is held by i_out_stall.
    aldp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Back: pdf = 2^16 * py^2 * q * sqrt(q) / (m^3 * w * h), truncated,
    // saturated at full scale. Freezes as a whole while the output is held.
    aldp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .i_light_width  (r_light_width),
        .i_light_height (r_light_height),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_pdf_value    (o_pdf_value),
        .o_saturated    (o_saturated)
    );

endmodule

`default_nettype wire
